// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the block's RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
   `ASSERT_PROP(lbl, clk, rst, !(cond), msg)

`endif

// ===== rtl/mvm_pkg.sv =====
// ----------------------------------------------------------------------------
// mvm_pkg
// Types, sizes and codes shared by the matrix-vector multiply modules.
// ----------------------------------------------------------------------------
package mvm_pkg;

   // Vector store depth and derived widths
   localparam int unsigned MAX_SIZE = 256;
   localparam int unsigned POS_W    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int unsigned COL_W    = 9;
   localparam int unsigned CMP_W    = ((POS_W > COL_W) ? POS_W : COL_W) + 1;

   // Row band sizes
   localparam int unsigned ROW_W    = 8;
   localparam int unsigned ROWS_W   = 9;
   localparam int unsigned ROW_SPAN = 256;

   // Element and sum widths
   localparam int unsigned ELEM_W   = 32;
   localparam int unsigned SUM_W    = 64;

   // Queue between front and back
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = QPTR_W + 1;

   // Configuration register indexes
   localparam int unsigned CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COLUMNS_IN_USE = 2'd0,
      CSR_FIRST_ROW      = 2'd1,
      CSR_ROWS_IN_BAND   = 2'd2
   } csr_index_type;

   // Request opcodes
   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_MATRIX = 1'b1
   } opcode_type;

   // Effective configuration seen by the front
   typedef struct packed {
      logic [CMP_W-1:0]  eff_cols;
      logic [ROW_W-1:0]  first_row;
      logic [ROWS_W-1:0] eff_rows;
   } cfg_type;

   // One multiply-accumulate operation handed from front to back
   typedef struct packed {
      logic signed [ELEM_W-1:0] elem;
      logic signed [ELEM_W-1:0] vec;
      logic                     row_done;
      logic [ROW_W-1:0]         row_index;
      logic                     last_row;
   } op_type;

endpackage

// ===== rtl/mvm_csr.sv =====
// ----------------------------------------------------------------------------
// mvm_csr
// Configuration registers with clamping to effective column and row counts.
// ----------------------------------------------------------------------------
module mvm_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mvm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mvm_pkg::COL_W-1:0]         csr_data,
   output mvm_pkg::cfg_type                  cfg
);
   import mvm_pkg::*;

   logic [COL_W-1:0]  columns_ff, columns_in;
   logic [ROW_W-1:0]  first_row_ff, first_row_in;
   logic [ROWS_W-1:0] rows_ff, rows_in;
   logic [CMP_W-1:0]  cols_nz;

   assign csr_ready = 1'b1;

   // Register write decode
   always_comb begin
      columns_in   = columns_ff;
      first_row_in = first_row_ff;
      rows_in      = rows_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_COLUMNS_IN_USE: columns_in   = csr_data;
            CSR_FIRST_ROW:      first_row_in = csr_data[ROW_W-1:0];
            CSR_ROWS_IN_BAND:   rows_in      = csr_data[ROWS_W-1:0];
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff   <= COL_W'(MAX_SIZE > 256 ? 256 : MAX_SIZE);
         first_row_ff <= '0;
         rows_ff      <= ROWS_W'(ROW_SPAN);
      end else begin
         columns_ff   <= columns_in;
         first_row_ff <= first_row_in;
         rows_ff      <= rows_in;
      end
   end

   // Zero acts as one, too large clamps to the limit
   always_comb begin
      cols_nz = (columns_ff == '0) ? CMP_W'(1) : CMP_W'(columns_ff);
      cfg.eff_cols  = (cols_nz > CMP_W'(MAX_SIZE)) ? CMP_W'(MAX_SIZE) : cols_nz;
      cfg.first_row = first_row_ff;
      if (rows_ff == '0) begin
         cfg.eff_rows = ROWS_W'(1);
      end else if (rows_ff > ROWS_W'(ROW_SPAN)) begin
         cfg.eff_rows = ROWS_W'(ROW_SPAN);
      end else begin
         cfg.eff_rows = rows_ff;
      end
   end

endmodule

// ===== rtl/mvm_front.sv =====
// ----------------------------------------------------------------------------
// mvm_front
// Accepts transactions, tracks load, column and row positions, owns the
// vector store and issues one MAC operation per matrix element.
// ----------------------------------------------------------------------------
module mvm_front (
   input  logic                              clock,
   input  logic                              reset,
   input  mvm_pkg::cfg_type                  cfg,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic signed [mvm_pkg::ELEM_W-1:0] req_element_value,
   input  logic [mvm_pkg::QCNT_W-1:0]        q_level,
   output logic                              push_valid,
   output mvm_pkg::op_type                   push_data
);
   import mvm_pkg::*;

   logic [POS_W-1:0]  load_pos_ff, load_pos_in;
   logic [POS_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic              s1_valid_ff;
   op_type            s1_op_ff, s1_op_in;
   logic signed [ELEM_W-1:0] vec_rd_ff;
   logic signed [ELEM_W-1:0] vec_mem [MAX_SIZE];

   logic              accept;
   logic              is_matrix;
   logic [CMP_W-1:0]  pos_c, pos_n, col_c, col_n;
   logic [ROWS_W-1:0] row_c, row_n;
   logic              row_done, last_row;
   logic [POS_W-1:0]  mem_addr;
   logic [QCNT_W:0]   pending;

   // Room in the queue counting the operation still in the read stage
   assign pending   = {1'b0, q_level} + (QCNT_W+1)'(s1_valid_ff);
   assign req_ready = pending < (QCNT_W+1)'(QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;
   assign is_matrix = (req_opcode == OP_MATRIX);

   // Position counters, clamped to the current limits
   always_comb begin
      pos_c = (CMP_W'(load_pos_ff) >= cfg.eff_cols) ? cfg.eff_cols - CMP_W'(1)
                                                     : CMP_W'(load_pos_ff);
      pos_n = pos_c + CMP_W'(1);
      col_c = (CMP_W'(col_ff) >= cfg.eff_cols) ? cfg.eff_cols - CMP_W'(1)
                                                : CMP_W'(col_ff);
      col_n = col_c + CMP_W'(1);
      row_done = (col_n >= cfg.eff_cols);
      row_c = (ROWS_W'(row_ff) >= cfg.eff_rows) ? cfg.eff_rows - ROWS_W'(1)
                                                 : ROWS_W'(row_ff);
      row_n = row_c + ROWS_W'(1);
      last_row = (row_n >= cfg.eff_rows);

      load_pos_in = load_pos_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      if (accept && !is_matrix) begin
         load_pos_in = (pos_n >= cfg.eff_cols) ? '0 : pos_n[POS_W-1:0];
      end
      if (accept && is_matrix) begin
         col_in = row_done ? '0 : col_n[POS_W-1:0];
         if (row_done) begin
            row_in = last_row ? '0 : row_n[ROW_W-1:0];
         end
      end

      mem_addr = is_matrix ? col_c[POS_W-1:0] : pos_c[POS_W-1:0];

      s1_op_in           = s1_op_ff;
      s1_op_in.elem      = req_element_value;
      s1_op_in.vec       = '0;
      s1_op_in.row_done  = row_done;
      s1_op_in.row_index = cfg.first_row + row_c[ROW_W-1:0];
      s1_op_in.last_row  = last_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         load_pos_ff <= load_pos_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept && is_matrix;
      end
   end

   // Operation payload for the read stage
   always_ff @(posedge clock) begin
      if (accept && is_matrix) begin
         s1_op_ff <= s1_op_in;
      end
   end

   // Vector store: single port, write for loads, registered read for matrix
   always_ff @(posedge clock) begin
      if (accept) begin
         if (is_matrix) begin
            vec_rd_ff <= vec_mem[mem_addr];
         end else begin
            vec_mem[mem_addr] <= req_element_value;
         end
      end
   end

   // Hand the operation with its vector element to the queue
   always_comb begin
      push_valid    = s1_valid_ff;
      push_data     = s1_op_ff;
      push_data.vec = vec_rd_ff;
   end

endmodule

// ===== rtl/mvm_queue.sv =====
// ----------------------------------------------------------------------------
// mvm_queue
// Short FIFO of MAC operations between the front and the back.
// ----------------------------------------------------------------------------
module mvm_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   input  mvm_pkg::op_type            push_data,
   output logic                       pop_valid,
   input  logic                       pop,
   output mvm_pkg::op_type            pop_data,
   output logic [mvm_pkg::QCNT_W-1:0] level
);
   import mvm_pkg::*;

   op_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_pop;

   assign pop_valid = (count_ff != '0);
   assign do_pop    = pop && pop_valid;
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign level     = count_ff;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push_valid) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/mvm_back.sv =====
// ----------------------------------------------------------------------------
// mvm_back
// Multiply stage, saturating accumulator and result register.
// ----------------------------------------------------------------------------
module mvm_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pop_valid,
   output logic                              pop,
   input  mvm_pkg::op_type                   pop_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mvm_pkg::ROW_W-1:0]         rsp_row_index,
   output logic signed [mvm_pkg::SUM_W-1:0]  rsp_dot_product,
   output logic                              rsp_saturated,
   output logic                              rsp_last_row
);
   import mvm_pkg::*;

   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   logic                     m_valid_ff;
   logic signed [SUM_W-1:0]  m_prod_ff;
   logic                     m_row_done_ff;
   logic [ROW_W-1:0]         m_row_index_ff;
   logic                     m_last_ff;

   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic                     clip_ff, clip_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic signed [ELEM_W-1:0] mul_a, mul_b;
   logic signed [SUM_W-1:0]  product;
   logic [SUM_W:0]           wide_sum;
   logic                     ovf;
   logic signed [SUM_W-1:0]  next_sum;
   logic                     adv_acc;

   // Multiply stage feed
   assign mul_a   = pop_data.elem;
   assign mul_b   = pop_data.vec;
   assign product = mul_a * mul_b;
   assign adv_acc = m_valid_ff && (!m_row_done_ff || !rsp_valid_ff || rsp_ready);
   assign pop     = pop_valid && (!m_valid_ff || adv_acc);

   // Saturating add of the registered product
   always_comb begin
      wide_sum = {sum_ff[SUM_W-1], sum_ff} + {m_prod_ff[SUM_W-1], m_prod_ff};
      ovf      = (wide_sum[SUM_W] != wide_sum[SUM_W-1]);
      next_sum = ovf ? (m_prod_ff[SUM_W-1] ? SUM_MIN : SUM_MAX)
                     : signed'(wide_sum[SUM_W-1:0]);

      sum_in       = sum_ff;
      clip_in      = clip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (adv_acc) begin
         if (m_row_done_ff) begin
            sum_in       = '0;
            clip_in      = 1'b0;
            rsp_valid_in = 1'b1;
         end else begin
            sum_in  = next_sum;
            clip_in = clip_ff || ovf;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff   <= 1'b0;
         sum_ff       <= '0;
         clip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         m_valid_ff   <= pop || (m_valid_ff && !adv_acc);
         sum_ff       <= sum_in;
         clip_ff      <= clip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Product register
   always_ff @(posedge clock) begin
      if (pop) begin
         m_prod_ff      <= product;
         m_row_done_ff  <= pop_data.row_done;
         m_row_index_ff <= pop_data.row_index;
         m_last_ff      <= pop_data.last_row;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (adv_acc && m_row_done_ff) begin
         rsp_row_index   <= m_row_index_ff;
         rsp_dot_product <= next_sum;
         rsp_saturated   <= clip_ff || ovf;
         rsp_last_row    <= m_last_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/matrix_vector_multiply.sv =====
// ----------------------------------------------------------------------------
// matrix_vector_multiply
// One transaction per cycle while req_ready is high; a row result is valid after
// the row's last matrix element passes the read stage, queue, multiply and add.
// The rate is set by the single-port vector store and the one MAC unit.
// Synchronous reset clears counters, queue and result valid, and restores
// 256 columns, first row 0 and 256 rows; the vector store is not cleared.
// ----------------------------------------------------------------------------
module matrix_vector_multiply (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic signed [mvm_pkg::ELEM_W-1:0] req_element_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mvm_pkg::ROW_W-1:0]         rsp_row_index,
   output logic signed [mvm_pkg::SUM_W-1:0]  rsp_dot_product,
   output logic                              rsp_saturated,
   output logic                              rsp_last_row,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mvm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mvm_pkg::COL_W-1:0]         csr_data
);
   import mvm_pkg::*;
   `include "assert_macros.svh"

   cfg_type             cfg;
   logic                push_valid;
   op_type              push_data;
   logic                pop_valid;
   logic                pop;
   op_type              pop_data;
   logic [QCNT_W-1:0]   q_level;
   logic                q_full;
   logic                mat_fire;
   logic                load_fire;

   mvm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mvm_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_element_value (req_element_value),
      .q_level           (q_level),
      .push_valid        (push_valid),
      .push_data         (push_data)
   );

   mvm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data),
      .level      (q_level)
   );

   mvm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop             (pop),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_row_index   (rsp_row_index),
      .rsp_dot_product (rsp_dot_product),
      .rsp_saturated   (rsp_saturated),
      .rsp_last_row    (rsp_last_row)
   );

   // Terms used by the checks below
   assign q_full    = (q_level == QCNT_W'(QUEUE_DEPTH));
   assign mat_fire  = req_valid && req_ready && (req_opcode == OP_MATRIX);
   assign load_fire = req_valid && req_ready && (req_opcode == OP_LOAD);

   // Queue never overflows under the front's credit check
   `ASSERT_NEVER(a_queue_overflow, clock, reset, push_valid && !pop && q_full, "queue overflow")
   // Every accepted matrix element reaches the queue in the next cycle
   `ASSERT_PROP(a_matrix_pushed, clock, reset, mat_fire |=> push_valid, "matrix element lost")
   // A vector load produces no MAC operation
   `ASSERT_PROP(a_load_not_pushed, clock, reset, load_fire |=> !push_valid, "vector load forwarded")

endmodule
